// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants for the point projection pipeline
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam logic [12:0] SCREEN_W = 13'd1920;
  localparam logic [12:0] SCREEN_H = 13'd1080;

  localparam int unsigned NumCells = 13;  // one cell per bit of the screen size
  localparam int unsigned DivW     = 55;  // width of 2*depth and remainders

  typedef enum logic [2:0] {
    CfgCamPosX   = 3'd0,
    CfgCamPosY   = 3'd1,
    CfgCamPosZ   = 3'd2,
    CfgCosYaw    = 3'd3,
    CfgSinYaw    = 3'd4,
    CfgCosPitch  = 3'd5,
    CfgSinPitch  = 3'd6,
    CfgFovScale  = 3'd7
  } cfg_idx_e;

  // payload carried along the divider chain
  typedef struct packed {
    logic [DivW-1:0] rx;
    logic [DivW-1:0] ry;
    logic [12:0]     qx;
    logic [12:0]     qy;
    logic [DivW-1:0] nx;
    logic [DivW-1:0] ny;
    logic [DivW-1:0] m;
    logic            vis;
  } div_t;

endpackage

// ===== hw/rtl/pps_point_if.sv =====
// ----------------------------------------------------------------------------
// pps_point_if
// request channel carrying one world point
// ----------------------------------------------------------------------------
interface pps_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== hw/rtl/pps_screen_if.sv =====
// ----------------------------------------------------------------------------
// pps_screen_if
// request channel carrying one projected screen position
// ----------------------------------------------------------------------------
interface pps_screen_if;
  logic        valid;
  logic        ready;
  logic [12:0] screen_x;
  logic [12:0] screen_y;
  logic        visible;

  modport source (output valid, screen_x, screen_y, visible, input ready);
  modport sink   (input valid, screen_x, screen_y, visible, output ready);
endinterface

// ===== hw/rtl/perspective_point_projection.sv =====
// ----------------------------------------------------------------------------
// perspective_point_projection
// camera transform, frustum test and pixel mapping of one point per cycle
// ----------------------------------------------------------------------------
// stages: 7 transform stages, 13 divide cells, one output register
// throughput: one point per cycle; every stage stalls only when the one after
//   it is full and held
// reset: pipeline emptied, registers back to identity camera at the origin
module perspective_point_projection (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  pps_point_if.sink     point_i,
  pps_screen_if.source  screen_o
);
  import pps_pkg::*;

  // configuration
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [15:0] cos_y_q, sin_y_q, cos_p_q, sin_p_q;
  logic        [23:0] fov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      cos_y_q <= 16'sd16384;
      sin_y_q <= '0;
      cos_p_q <= 16'sd16384;
      sin_p_q <= '0;
      fov_q   <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCamPosX:  cam_x_q <= cfg_data_i;
        CfgCamPosY:  cam_y_q <= cfg_data_i;
        CfgCamPosZ:  cam_z_q <= cfg_data_i;
        CfgCosYaw:   cos_y_q <= cfg_data_i[15:0];
        CfgSinYaw:   sin_y_q <= cfg_data_i[15:0];
        CfgCosPitch: cos_p_q <= cfg_data_i[15:0];
        CfgSinPitch: sin_p_q <= cfg_data_i[15:0];
        CfgFovScale: fov_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_v_q;
  logic a1, a2, a3, a4, a5, a6, a7, out_a;
  logic [NumCells-1:0] cv;
  logic [NumCells-1:0] cadv;

  assign out_a = !out_v_q || screen_o.ready;
  assign cadv[NumCells-1] = !cv[NumCells-1] || out_a;
  for (genvar k = 0; k < NumCells - 1; k++) begin : g_adv
    assign cadv[k] = !cv[k] || cadv[k+1];
  end
  assign a7 = !v7_q || cadv[0];
  assign a6 = !v6_q || a7;
  assign a5 = !v5_q || a6;
  assign a4 = !v4_q || a5;
  assign a3 = !v3_q || a4;
  assign a2 = !v2_q || a3;
  assign a1 = !v1_q || a2;
  assign point_i.ready = a1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (a1)    v1_q    <= point_i.valid;
      if (a2)    v2_q    <= v1_q;
      if (a3)    v3_q    <= v2_q;
      if (a4)    v4_q    <= v3_q;
      if (a5)    v5_q    <= v4_q;
      if (a6)    v6_q    <= v5_q;
      if (a7)    v7_q    <= v6_q;
      if (out_a) out_v_q <= cv[NumCells-1];
    end
  end

  // stage 1: offset from camera
  logic signed [32:0] dx_q, dy_q, dz_q;
  // stage 2: yaw products
  logic signed [48:0] pxc_q, pzs_q, pxs_q, pzc_q;
  logic signed [32:0] dy2_q;
  // stage 3: yaw sums
  logic signed [35:0] x1_q, z1_q;
  logic signed [32:0] dy3_q;
  logic signed [49:0] yaw_a, yaw_b;
  // stage 4: pitch products
  logic signed [48:0] pyc_q, pys_q;
  logic signed [51:0] pzsp_q, pzcp_q;
  logic signed [35:0] x14_q;
  // stage 5: pitch sums
  logic signed [35:0] x15_q;
  logic signed [38:0] y2_q, z2_q;
  logic signed [52:0] pit_a, pit_b;
  // stage 6: fov scaling
  logic [35:0] magx;
  logic [38:0] magy;
  logic [59:0] ax_q;
  logic [62:0] ay_q;
  logic [53:0] dd_q;
  logic        xneg_q, yneg_q, pos_q;
  // stage 7: frustum test
  div_t        s7_q, s7_d;

  assign yaw_a = {pxc_q[48], pxc_q} - {pzs_q[48], pzs_q};
  assign yaw_b = {pxs_q[48], pxs_q} + {pzc_q[48], pzc_q};
  assign pit_a = {{4{pyc_q[48]}}, pyc_q} - {pzsp_q[51], pzsp_q};
  assign pit_b = {{4{pys_q[48]}}, pys_q} + {pzcp_q[51], pzcp_q};
  assign magx  = x15_q[35] ? 36'(-x15_q) : 36'(x15_q);
  assign magy  = y2_q[38] ? 39'(-y2_q) : 39'(y2_q);

  always_comb begin
    logic [54:0] dd;
    logic [54:0] ax;
    logic [54:0] ay;
    dd   = {1'b0, dd_q};
    ax   = ax_q[54:0];
    ay   = ay_q[54:0];
    s7_d = '0;
    s7_d.vis = pos_q && ({3'b000, ax_q} <= {9'd0, dd_q})
                     && (ay_q <= {9'd0, dd_q});
    s7_d.nx  = xneg_q ? dd - ax : dd + ax;
    s7_d.ny  = yneg_q ? dd + ay : dd - ay;
    s7_d.m   = {dd_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (a1) begin
      dx_q <= $signed({point_i.point_x[31], point_i.point_x}) - $signed({cam_x_q[31], cam_x_q});
      dy_q <= $signed({point_i.point_y[31], point_i.point_y}) - $signed({cam_y_q[31], cam_y_q});
      dz_q <= $signed({point_i.point_z[31], point_i.point_z}) - $signed({cam_z_q[31], cam_z_q});
    end
    if (a2) begin
      pxc_q <= dx_q * cos_y_q;
      pzs_q <= dz_q * sin_y_q;
      pxs_q <= dx_q * sin_y_q;
      pzc_q <= dz_q * cos_y_q;
      dy2_q <= dy_q;
    end
    if (a3) begin
      // upper bits of the sum are the floor of the q14 quotient
      x1_q  <= yaw_a[49:14];
      z1_q  <= yaw_b[49:14];
      dy3_q <= dy2_q;
    end
    if (a4) begin
      pyc_q  <= dy3_q * cos_p_q;
      pys_q  <= dy3_q * sin_p_q;
      pzsp_q <= z1_q * sin_p_q;
      pzcp_q <= z1_q * cos_p_q;
      x14_q  <= x1_q;
    end
    if (a5) begin
      y2_q  <= pit_a[52:14];
      z2_q  <= pit_b[52:14];
      x15_q <= x14_q;
    end
    if (a6) begin
      ax_q   <= magx * fov_q;
      ay_q   <= magy * fov_q;
      dd_q   <= {z2_q[37:0], 16'd0};
      xneg_q <= x15_q[35];
      yneg_q <= y2_q[38];
      pos_q  <= !z2_q[38] && (z2_q != '0);
    end
    if (a7) begin
      s7_q <= s7_d;
    end
  end

  // divider chain
  div_t cin  [NumCells];
  div_t cout [NumCells];

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cin[k] = s7_q;
    end else begin : g_rest
      assign cin[k] = cout[k-1];
    end
    pps_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (cadv[k]),
      .valid_i ((k == 0) ? v7_q : cv[(k == 0) ? 0 : k-1]),
      .wx_i    (SCREEN_W[NumCells-1-k]),
      .wy_i    (SCREEN_H[NumCells-1-k]),
      .in_i    (cin[k]),
      .valid_o (cv[k]),
      .out_o   (cout[k])
    );
  end

  // output register
  logic [12:0] sx_q, sy_q;
  logic        vis_q;

  always_ff @(posedge clk_i) begin
    if (out_a) begin
      vis_q <= cout[NumCells-1].vis;
      sx_q  <= cout[NumCells-1].vis ? cout[NumCells-1].qx : '0;
      sy_q  <= cout[NumCells-1].vis ? cout[NumCells-1].qy : '0;
    end
  end

  assign screen_o.valid    = out_v_q;
  assign screen_o.screen_x = sx_q;
  assign screen_o.screen_y = sy_q;
  assign screen_o.visible  = vis_q;

`ifndef SYNTHESIS
  a_hidden_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (screen_o.valid && !screen_o.visible) |-> (screen_o.screen_x == '0 &&
      screen_o.screen_y == '0))
    else $error("hidden point with nonzero position");

  a_on_screen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (screen_o.valid && screen_o.visible) |-> (screen_o.screen_x <= SCREEN_W &&
      screen_o.screen_y <= SCREEN_H))
    else $error("visible point off screen");

  a_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (screen_o.valid && !screen_o.ready) |=> screen_o.valid)
    else $error("waiting result dropped");
`endif

endmodule

// ===== hw/rtl/pps_div_cell.sv =====
// ----------------------------------------------------------------------------
// pps_div_cell
// one step of the scaled divide: takes one bit of the screen size per lane
// ----------------------------------------------------------------------------
module pps_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          wx_i,
  input  logic          wy_i,
  input  pps_pkg::div_t in_i,
  output logic          valid_o,
  output pps_pkg::div_t out_o
);
  import pps_pkg::*;

  logic   valid_q;
  div_t   data_q, data_d;

  // remainder stays below m, so the new partial sum stays below 3m
  function automatic logic [DivW+13:0] step(input logic [DivW-1:0] r,
                                            input logic [DivW-1:0] n,
                                            input logic [DivW-1:0] m,
                                            input logic            bit_in,
                                            input logic [12:0]     q);
    logic [DivW+1:0] t;
    logic [DivW+1:0] m1;
    logic [DivW+1:0] m2;
    logic [DivW+1:0] res;
    logic [12:0]     qn;
    t  = {1'b0, r, 1'b0} + (bit_in ? {2'b00, n} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    qn = {q[11:0], 1'b0};
    if (t >= m2) begin
      res = t - m2;
      qn  = qn + 13'd2;
    end else if (t >= m1) begin
      res = t - m1;
      qn  = qn + 13'd1;
    end else begin
      res = t;
    end
    return {res[DivW-1:0], qn, 1'b0};
  endfunction

  logic [DivW+13:0] sx, sy;

  always_comb begin
    sx = step(in_i.rx, in_i.nx, in_i.m, wx_i, in_i.qx);
    sy = step(in_i.ry, in_i.ny, in_i.m, wy_i, in_i.qy);
    data_d    = in_i;
    data_d.rx = sx[DivW+13:14];
    data_d.qx = sx[13:1];
    data_d.ry = sy[DivW+13:14];
    data_d.qy = sy[13:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = data_q;

endmodule
